@@ design/mpsp_pkg.sv @@
package mpsp_pkg;

   // Start-code window: three prefix bytes and the id byte.
   localparam int WIN_BYTES = 4;
   localparam int WIN_IDX_W = $clog2(WIN_BYTES);
   localparam logic [2:0] WIN_FULL = 3'd4;

   // Entries in the queue between the parser and the output serialiser.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Stream ids of interest.
   localparam logic [7:0] ID_PACK = 8'hBA;
   localparam logic [7:0] ID_SYS_HDR = 8'hBB;
   localparam logic [7:0] ID_LOWEST = 8'hBD;
   localparam logic [7:0] ID_HIGHEST = 8'hFE;

   // Top nibble of the fifth pack header byte that marks the MPEG-2 format.
   localparam logic [3:0] PACK_MPEG2_NIBBLE = 4'h4;

   // Bytes of a pack header still to come after its fifth byte.
   localparam logic [15:0] PACK_LEFT_MPEG1 = 16'd7;
   localparam logic [15:0] PACK_LEFT_MPEG2 = 16'd9;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_KIND = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESYNC_AT_START = 1'd1;

   // One queue entry: up to four words that share an id and a format flag.
   // The first flag belongs to the entry's first word, the last flag to its
   // final word, which sits at position last_idx.
   typedef struct packed {
      logic [WIN_BYTES-1:0][7:0] data;
      logic [WIN_IDX_W-1:0]      last_idx;
      logic                      first;
      logic                      last;
      logic [7:0]                id;
      logic                      mpeg2;
   } mpsp_entry_type;

endpackage

@@ design/mpsp_front.sv @@
module mpsp_front import mpsp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_drain,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_wdata,
   input  logic                 q_full,
   output logic                 q_push,
   output mpsp_entry_type       q_entry
);

   localparam logic [2:0] PH_HUNT   = 3'd0;
   localparam logic [2:0] PH_PACK5  = 3'd1;
   localparam logic [2:0] PH_LENHI  = 3'd2;
   localparam logic [2:0] PH_LENLO  = 3'd3;
   localparam logic [2:0] PH_BODY   = 3'd4;
   localparam logic [2:0] PH_VCHUNK = 3'd5;

   logic [WIN_BYTES-1:0][7:0] win_ff, win_in;
   logic [2:0]                held_ff, held_in;
   logic [2:0]                phase_ff, phase_in;
   logic [15:0]               left_ff, left_in;
   logic [7:0]                id_ff, id_in;
   logic                      mpeg2_ff, mpeg2_in;
   logic                      await_ff, await_in;
   logic                      kind_ff, kind_in;

   logic                      accept;
   logic [WIN_BYTES-1:0][7:0] win_sh;
   logic [2:0]                held_sh;
   logic                      code;
   logic [7:0]                code_id;
   logic                      skip_id;
   logic                      pack_m2;
   logic [15:0]               len_full;
   logic [15:0]               left_dec;
   logic [2:0]                vcount;
   logic                      found;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Window after taking the incoming byte.
   always_comb begin
      win_sh  = win_ff;
      held_sh = held_ff;
      if (held_ff == WIN_FULL) begin
         win_sh = {req_data_byte, win_ff[WIN_BYTES-1:1]};
      end else begin
         win_sh[held_ff[WIN_IDX_W-1:0]] = req_data_byte;
         held_sh = held_ff + 3'd1;
      end
   end

   assign code     = (held_sh == WIN_FULL) && (win_sh[0] == 8'h00) &&
                     (win_sh[1] == 8'h00) && (win_sh[2] == 8'h01);
   assign code_id  = win_sh[3];
   assign skip_id  = await_ff || ((code_id != ID_SYS_HDR) && mpeg2_ff &&
                     ((code_id < ID_LOWEST) || (code_id > ID_HIGHEST)));
   assign pack_m2  = (req_data_byte[7:4] == PACK_MPEG2_NIBBLE);
   assign len_full = {left_ff[15:8], req_data_byte};
   assign left_dec = (left_ff != 16'd0) ? (left_ff - 16'd1) : 16'd0;
   assign vcount   = (left_ff[2:0] < 3'd4) ? (left_ff[2:0] + 3'd1) : left_ff[2:0];
   assign found    = (vcount >= 3'd4) && code;

   always_comb begin
      win_in   = win_ff;
      held_in  = held_ff;
      phase_in = phase_ff;
      left_in  = left_ff;
      id_in    = id_ff;
      mpeg2_in = mpeg2_ff;
      await_in = await_ff;
      kind_in  = kind_ff;

      q_push            = 1'b0;
      q_entry.data      = {WIN_BYTES{req_data_byte}};
      q_entry.last_idx  = '0;
      q_entry.first     = 1'b0;
      q_entry.last      = 1'b0;
      q_entry.id        = id_ff;
      q_entry.mpeg2     = mpeg2_ff;

      if (accept) begin
         if (req_drain) begin
            // Only an open video chunk keeps its held bytes on a drain.
            if ((phase_ff == PH_VCHUNK) && (held_ff != 3'd0)) begin
               q_push           = 1'b1;
               q_entry.data     = win_ff;
               q_entry.last_idx = WIN_IDX_W'(held_ff - 3'd1);
               q_entry.first    = (left_ff == 16'd0);
               q_entry.last     = 1'b1;
            end
            held_in  = 3'd0;
            left_in  = 16'd0;
            phase_in = PH_HUNT;
         end else begin
            case (phase_ff)
               PH_HUNT: begin
                  win_in  = win_sh;
                  held_in = held_sh;
                  if (code) begin
                     id_in = code_id;
                     if (kind_ff) begin
                        left_in  = 16'd0;
                        phase_in = PH_VCHUNK;
                     end else if (code_id == ID_PACK) begin
                        await_in         = 1'b0;
                        q_push           = 1'b1;
                        q_entry.data     = win_sh;
                        q_entry.last_idx = WIN_IDX_W'(WIN_BYTES - 1);
                        q_entry.first    = 1'b1;
                        q_entry.id       = code_id;
                        held_in          = 3'd0;
                        phase_in         = PH_PACK5;
                     end else if (skip_id) begin
                        held_in = 3'd0;
                     end else begin
                        q_push           = 1'b1;
                        q_entry.data     = win_sh;
                        q_entry.last_idx = WIN_IDX_W'(WIN_BYTES - 1);
                        q_entry.first    = 1'b1;
                        q_entry.id       = code_id;
                        held_in          = 3'd0;
                        phase_in         = PH_LENHI;
                     end
                  end
               end
               PH_PACK5: begin
                  mpeg2_in      = pack_m2;
                  left_in       = pack_m2 ? PACK_LEFT_MPEG2 : PACK_LEFT_MPEG1;
                  q_push        = 1'b1;
                  q_entry.mpeg2 = pack_m2;
                  phase_in      = PH_BODY;
               end
               PH_LENHI: begin
                  left_in  = {req_data_byte, 8'h00};
                  q_push   = 1'b1;
                  phase_in = PH_LENLO;
               end
               PH_LENLO: begin
                  q_push = 1'b1;
                  if (len_full == 16'd0) begin
                     q_entry.last = 1'b1;
                     held_in      = 3'd0;
                     left_in      = 16'd0;
                     phase_in     = PH_HUNT;
                  end else begin
                     left_in  = len_full;
                     phase_in = PH_BODY;
                  end
               end
               PH_BODY: begin
                  q_push = 1'b1;
                  if (left_dec == 16'd0) begin
                     q_entry.last = 1'b1;
                     held_in      = 3'd0;
                     left_in      = 16'd0;
                     phase_in     = PH_HUNT;
                  end else begin
                     left_in = left_dec;
                  end
               end
               PH_VCHUNK: begin
                  // The byte leaving the window goes out with the current id.
                  win_in        = win_sh;
                  held_in       = held_sh;
                  q_push        = 1'b1;
                  q_entry.data  = win_ff;
                  q_entry.first = (vcount == 3'd1);
                  q_entry.last  = found;
                  if (found) begin
                     id_in   = code_id;
                     left_in = 16'd0;
                  end else begin
                     left_in = {13'd0, vcount};
                  end
               end
               default: begin
                  held_in  = 3'd0;
                  left_in  = 16'd0;
                  phase_in = PH_HUNT;
               end
            endcase
         end
      end

      if (csr_write_en) begin
         case (csr_index)
            CSR_STREAM_KIND: begin
               kind_in  = csr_wdata;
               held_in  = 3'd0;
               left_in  = 16'd0;
               phase_in = PH_HUNT;
            end
            CSR_RESYNC_AT_START: begin
               await_in = csr_wdata;
            end
            default: begin
               kind_in = kind_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 3'd0;
         phase_ff <= PH_HUNT;
         left_ff  <= 16'd0;
         id_ff    <= 8'h00;
         mpeg2_ff <= 1'b0;
         await_ff <= 1'b0;
         kind_ff  <= 1'b0;
      end else begin
         held_ff  <= held_in;
         phase_ff <= phase_in;
         left_ff  <= left_in;
         id_ff    <= id_in;
         mpeg2_ff <= mpeg2_in;
         await_ff <= await_in;
         kind_ff  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

@@ design/mpsp_queue.sv @@
module mpsp_queue import mpsp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  mpsp_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output mpsp_entry_type head,
   output logic           empty
);

   mpsp_entry_type    mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == QCNT_W'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : (wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : (rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The parser must never offer a word group when there is no room.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue read while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count lost a write");

endmodule

@@ design/mpsp_back.sv @@
module mpsp_back import mpsp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_empty,
   input  mpsp_entry_type q_head,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_first_of_packet,
   output logic           rsp_last_of_packet,
   output logic [7:0]     rsp_packet_id,
   output logic           rsp_is_mpeg2
);

   logic [WIN_IDX_W-1:0] sub_ff, sub_in;
   logic                 valid_ff;
   logic [7:0]           byte_ff;
   logic                 first_ff;
   logic                 last_ff;
   logic [7:0]           id_ff;
   logic                 mpeg2_ff;
   logic                 load;
   logic                 at_end;

   // A new word enters the output register when it is empty or being taken.
   assign load   = !q_empty && (!valid_ff || rsp_ready);
   assign at_end = (sub_ff == q_head.last_idx);
   assign q_pop  = load && at_end;
   assign sub_in = at_end ? '0 : (sub_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         sub_ff   <= sub_in;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= q_head.data[sub_ff];
         first_ff <= q_head.first && (sub_ff == '0);
         last_ff  <= q_head.last && at_end;
         id_ff    <= q_head.id;
         mpeg2_ff <= q_head.mpeg2;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_out_byte        = byte_ff;
   assign rsp_first_of_packet = first_ff;
   assign rsp_last_of_packet  = last_ff;
   assign rsp_packet_id       = id_ff;
   assign rsp_is_mpeg2        = mpeg2_ff;

endmodule

@@ design/mpeg_program_stream_packetizer_unit.sv @@
// MPEG program-stream packetizer. Stream bytes enter on the req_ channel one word
// per cycle while req_ready is high; req_drain marks the end of the stream and
// carries no byte. A four-byte window finds 00 00 01 id start codes. In system
// mode each code opens a packet (a pack header of 12 or 14 bytes, which also sets
// the MPEG-2 flag, or a packet of 6 bytes plus its big-endian length), but in
// MPEG-2 only ids BA, BB and BD..FE are kept; in video mode each chunk runs from
// one start code to the next. Every packet byte leaves on the rsp_ channel tagged
// with the packet's id, its first and last marks and the MPEG-2 flag. The parser
// takes an input word in every cycle that the word queue has room, with its result
// known in the same cycle; it writes at most one group of up to four output words
// per input word into a four-entry queue. The output side sends one word per cycle
// while rsp_ready is high, so a start code's four header bytes occupy the output
// while the parser keeps accepting; sustained throughput is one byte per cycle,
// set by the output register. Words pass the queue, then the output register. No
// clearing pass follows reset. Configuration is written through csr_ with
// csr_index 0 selecting the stream kind (which also restarts the hunt for a start
// code) and 1 the resync flag (which arms dropping of start codes until the next
// pack header); the user must write only while the block is idle (not enforced).
module mpeg_program_stream_packetizer_unit import mpsp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_drain,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_first_of_packet,
   output logic                 rsp_last_of_packet,
   output logic [7:0]           rsp_packet_id,
   output logic                 rsp_is_mpeg2,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_wdata
);

   // Word groups travelling from the parser to the output serialiser.
   mpsp_entry_type push_entry;
   mpsp_entry_type head_entry;
   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_empty;

   // The parser holds all stream state and decides what each byte produces.
   mpsp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_drain     (req_drain),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   // The queue lets the parser run on while the output side is stalled.
   mpsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (head_entry),
      .empty      (q_empty)
   );

   // The serialiser breaks each group into single words for the output register.
   mpsp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_head              (head_entry),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_first_of_packet (rsp_first_of_packet),
      .rsp_last_of_packet  (rsp_last_of_packet),
      .rsp_packet_id       (rsp_packet_id),
      .rsp_is_mpeg2        (rsp_is_mpeg2)
   );

endmodule
